@@ design/cgs_pkg.sv @@
// Shared types, codes, step table and saturating Q32.32 helpers of the solver.
package cgs_pkg;

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] REQ_MAT   = 2'd0;
  localparam logic [1:0] REQ_RHS   = 2'd1;
  localparam logic [1:0] REQ_X     = 2'd2;
  localparam logic [1:0] REQ_SOLVE = 2'd3;

  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAXIT = 2'd1;
  localparam logic [1:0] CFG_TOL   = 2'd2;

  localparam logic [3:0] V_B   = 4'd0;
  localparam logic [3:0] V_X   = 4'd1;
  localparam logic [3:0] V_R   = 4'd2;
  localparam logic [3:0] V_P0  = 4'd3;
  localparam logic [3:0] V_P1  = 4'd4;
  localparam logic [3:0] V_AX  = 4'd5;
  localparam logic [3:0] V_AR  = 4'd6;
  localparam logic [3:0] V_AP0 = 4'd7;
  localparam logic [3:0] V_AP1 = 4'd8;

  localparam logic [4:0] STEP_SUB   = 5'd4;
  localparam logic [4:0] STEP_FIRST = 5'd5;
  localparam logic [4:0] STEP_MV_R  = 5'd6;
  localparam logic [4:0] STEP_MV_P1 = 5'd12;

  typedef enum logic [3:0] {
    OP_MV, OP_DOT, OP_SUB, OP_COPY, OP_AXPY, OP_ENERGY, OP_BETA, OP_ALPHA, OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] va;
    logic [3:0] vb;
    logic [3:0] vd;
    logic       sel;
  } desc_t;

  function automatic desc_t step_desc(input logic [4:0] step);
    desc_t d;
    d = '{op: OP_END, va: V_X, vb: V_X, vd: V_X, sel: 1'b0};
    case (step)
      5'd0:  d = '{op: OP_MV,     va: V_X,  vb: V_X,   vd: V_AX,  sel: 1'b0};
      5'd1:  d = '{op: OP_DOT,    va: V_X,  vb: V_AX,  vd: V_X,   sel: 1'b0};
      5'd2:  d = '{op: OP_DOT,    va: V_X,  vb: V_B,   vd: V_X,   sel: 1'b1};
      5'd3:  d = '{op: OP_ENERGY, va: V_X,  vb: V_X,   vd: V_X,   sel: 1'b0};
      5'd4:  d = '{op: OP_SUB,    va: V_B,  vb: V_AX,  vd: V_R,   sel: 1'b0};
      5'd5:  d = '{op: OP_COPY,   va: V_R,  vb: V_R,   vd: V_P1,  sel: 1'b0};
      5'd6:  d = '{op: OP_MV,     va: V_X,  vb: V_R,   vd: V_AR,  sel: 1'b0};
      5'd7:  d = '{op: OP_MV,     va: V_X,  vb: V_P0,  vd: V_AP0, sel: 1'b0};
      5'd8:  d = '{op: OP_DOT,    va: V_P0, vb: V_AR,  vd: V_X,   sel: 1'b0};
      5'd9:  d = '{op: OP_DOT,    va: V_P0, vb: V_AP0, vd: V_X,   sel: 1'b1};
      5'd10: d = '{op: OP_BETA,   va: V_X,  vb: V_X,   vd: V_X,   sel: 1'b0};
      5'd11: d = '{op: OP_AXPY,   va: V_R,  vb: V_P0,  vd: V_P1,  sel: 1'b0};
      5'd12: d = '{op: OP_MV,     va: V_X,  vb: V_P1,  vd: V_AP1, sel: 1'b0};
      5'd13: d = '{op: OP_DOT,    va: V_P1, vb: V_R,   vd: V_X,   sel: 1'b0};
      5'd14: d = '{op: OP_DOT,    va: V_P1, vb: V_AP1, vd: V_X,   sel: 1'b1};
      5'd15: d = '{op: OP_ALPHA,  va: V_X,  vb: V_X,   vd: V_X,   sel: 1'b0};
      5'd16: d = '{op: OP_AXPY,   va: V_X,  vb: V_P1,  vd: V_X,   sel: 1'b1};
      5'd17: d = '{op: OP_COPY,   va: V_P1, vb: V_P1,  vd: V_P0,  sel: 1'b0};
      default: d = '{op: OP_END,  va: V_X,  vb: V_X,   vd: V_X,   sel: 1'b0};
    endcase
    return d;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return Q_MAX;
    if (a[63] && b[63] && !s[63]) return Q_MIN;
    return s;
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (!a[63] && b[63] && s[63]) return Q_MAX;
    if (a[63] && !b[63] && !s[63]) return Q_MIN;
    return s;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg,
                                                  input logic ovf);
    if (neg) begin
      if (ovf || m[63]) return Q_MIN;
      return 64'd0 - m;
    end
    if (ovf || m[63]) return Q_MAX;
    return m;
  endfunction

endpackage

@@ design/cgs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module cgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cgs_fmul.sv @@
// Multi-cycle saturating Q32.32 multiplier built from four 32x32 partial products.
module cgs_fmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);
  import cgs_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_FIN1 = 4'b0100,
    M_FIN2 = 4'b1000
  } mstate_e;

  mstate_e            st_q, st_d;
  logic               done_q;
  logic [1:0]         cnt_q;
  logic [63:0]        ma_q, mb_q, q_q;
  logic               neg_q, ovf_q;
  logic [127:0]       acc_q;
  logic signed [63:0] p_q;
  logic [31:0]        ah, bh;
  logic [63:0]        pp;
  logic [127:0]       pp_sh;
  logic               rnd;

  assign ah  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign bh  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp  = ah * bh;
  assign rnd = neg_q && (acc_q[31:0] != 32'd0);

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      M_IDLE: if (start_i) st_d = M_MUL;
      M_MUL:  if (cnt_q == 2'd3) st_d = M_FIN1;
      M_FIN1: st_d = M_FIN2;
      M_FIN2: st_d = M_IDLE;
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == M_FIN2);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      M_IDLE: begin
        ma_q  <= mag(a_i);
        mb_q  <= mag(b_i);
        neg_q <= a_i[63] ^ b_i[63];
        acc_q <= '0;
        cnt_q <= 2'd0;
      end
      M_MUL: begin
        acc_q <= acc_q + pp_sh;
        cnt_q <= cnt_q + 2'd1;
      end
      M_FIN1: begin
        q_q   <= acc_q[95:32] + {63'd0, rnd};
        ovf_q <= (acc_q[127:96] != 32'd0) || (rnd && (&acc_q[95:32]));
      end
      M_FIN2: p_q <= from_mag(q_q, neg_q, ovf_q);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

@@ design/cgs_fdiv.sv @@
// Bit-serial restoring divider: saturated Q32.32 (num << 32) / den; zero for den == 0.
module cgs_fdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] q_o
);
  import cgs_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } dstate_e;

  dstate_e            st_q, st_d;
  logic               done_q;
  logic [6:0]         cnt_q;
  logic [127:0]       dvd_q;
  logic [63:0]        ud_q, r_q, ql_q;
  logic               neg_q, ovf_q, dzero_q;
  logic signed [63:0] q_q;
  logic [63:0]        rs;
  logic               take;

  assign rs   = {r_q[62:0], dvd_q[127]};
  assign take = r_q[63] || (rs >= ud_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      D_IDLE: if (start_i) st_d = D_RUN;
      D_RUN:  if (cnt_q == 7'd0) st_d = D_FIN;
      D_FIN:  st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == D_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      D_IDLE: begin
        dvd_q   <= {32'd0, mag(num_i), 32'd0};
        ud_q    <= mag(den_i);
        neg_q   <= num_i[63] ^ den_i[63];
        dzero_q <= (den_i == 64'sd0);
        r_q     <= '0;
        ql_q    <= '0;
        ovf_q   <= 1'b0;
        cnt_q   <= 7'd127;
      end
      D_RUN: begin
        dvd_q <= {dvd_q[126:0], 1'b0};
        ovf_q <= ovf_q | ql_q[63];
        ql_q  <= {ql_q[62:0], take};
        r_q   <= take ? (rs - ud_q) : rs;
        cnt_q <= cnt_q - 7'd1;
      end
      D_FIN: q_q <= dzero_q ? 64'sd0 : from_mag(ql_q, neg_q, ovf_q);
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

@@ design/conjugate_gradient_solver.sv @@
// Top level of the dense conjugate-gradient solver: sequencer, stores and arithmetic units.
// A load item (matrix, right-hand-side or start-solution entry) is written as it is
// accepted, and the block stays ready for the next one. A solve item holds the block for
// the whole run: every product goes through one shared multi-cycle multiplier with its
// memory reads and accumulation, and the two quotients of an iteration after the first
// go through the bit-serial divider. The first pass skips two matrix-vector products, two
// dot products, the direction update and the first quotient. The n solution elements then
// leave one at a time, each read in ST_OUTRD and loaded in ST_OUTCAP as the output side
// takes them. Matrix and vectors sit in two single-read-port memories; reads of solution
// entries never written since reset return zero.
module conjugate_gradient_solver #(
  parameter int MAX_N = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  row_i,
  input  logic [3:0]  col_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  index_o,
  output logic [63:0] solution_o,
  output logic        last_o,
  output logic        converged_o,
  output logic [15:0] iterations_used_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [40:0] cfg_data_i
);
  import cgs_pkg::*;

  localparam int IW  = $clog2(MAX_N);
  localparam int NW  = $clog2(MAX_N + 1);
  localparam int VAW = 4 + IW;
  localparam int MAW = 2 * IW;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'h0001,
    ST_STEP   = 13'h0002,
    ST_RDA    = 13'h0004,
    ST_RDB    = 13'h0008,
    ST_CAP    = 13'h0010,
    ST_MULW   = 13'h0020,
    ST_WB     = 13'h0040,
    ST_EN1    = 13'h0080,
    ST_EN2    = 13'h0100,
    ST_EN3    = 13'h0200,
    ST_DIVW   = 13'h0400,
    ST_OUTRD  = 13'h0800,
    ST_OUTCAP = 13'h1000
  } state_e;

  state_e             st_q, st_d;
  logic [4:0]         step_q, step_d;
  logic [IW-1:0]      i_q, j_q;
  logic [NW-1:0]      n_q, n_sel;
  logic [15:0]        iter_q;
  logic [16:0]        iter_inc;
  logic               cvg_q;
  logic [4:0]         size_q;
  logic [15:0]        maxit_q;
  logic [40:0]        tol_q;
  logic [MAX_N-1:0]   xvalid_q;
  logic               xmask_q;
  logic signed [63:0] acc_q, a_q, t0_q, t1_q, beta_q, alpha_q, prev_q, en_q, diff_q;
  logic signed [63:0] acc_new, wb_data;
  logic               out_valid_q, last_q, ocvg_q;
  logic [3:0]         index_q;
  logic [63:0]        sol_q;
  logic [15:0]        oiter_q;

  desc_t              desc;
  logic [IW-1:0]      nm1, row_idx, col_idx;
  logic               i_last, j_last, step_done, in_xfer, out_xfer, out_load;
  logic               row_ok, col_ok, is_mul;

  logic               vec_we, vec_re, mat_we, mat_re;
  logic [VAW-1:0]     vec_waddr, vec_raddr;
  logic [MAW-1:0]     mat_waddr, mat_raddr;
  logic [63:0]        vec_wdata, mat_wdata, vec_rdata, mat_rdata;
  logic signed [63:0] vec_rd;

  logic               mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_p, div_q;

  assign desc     = step_desc(step_q);
  assign nm1      = IW'(n_q - NW'(1));
  assign i_last   = (i_q == nm1);
  assign j_last   = (j_q == nm1);
  assign row_idx  = IW'(row_i);
  assign col_idx  = IW'(col_i);
  assign row_ok   = 32'(row_i) < MAX_N;
  assign col_ok   = 32'(col_i) < MAX_N;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign out_load = (st_q == ST_OUTCAP) && (!out_valid_q || out_ready_i);
  assign iter_inc = {1'b0, iter_q} + 17'd1;
  assign vec_rd   = xmask_q ? 64'sd0 : vec_rdata;
  assign is_mul   = (desc.op == OP_MV) || (desc.op == OP_DOT) || (desc.op == OP_AXPY);
  assign step_done = (desc.op == OP_MV) ? (j_last && i_last) : i_last;

  always_comb begin
    if (size_q == 5'd0) n_sel = NW'(1);
    else if (32'(size_q) > MAX_N) n_sel = NW'(MAX_N);
    else n_sel = NW'(size_q);
  end

  always_comb begin
    acc_new = sadd(acc_q, mul_p);
    case (desc.op)
      OP_SUB:  wb_data = ssub(a_q, vec_rd);
      OP_COPY: wb_data = a_q;
      OP_AXPY: wb_data = sadd(a_q, mul_p);
      default: wb_data = acc_new;
    endcase
  end

  always_comb begin
    if (step_q == STEP_SUB) step_d = (iter_q == 16'd0) ? STEP_FIRST : STEP_MV_R;
    else if (step_q == STEP_FIRST) step_d = STEP_MV_P1;
    else step_d = step_q + 5'd1;
  end

  always_comb begin
    vec_we    = 1'b0;
    vec_waddr = {V_B, i_q};
    vec_wdata = wb_data;
    vec_re    = 1'b0;
    vec_raddr = {desc.va, i_q};
    mat_we    = 1'b0;
    mat_waddr = {row_idx, col_idx};
    mat_wdata = value_i;
    mat_re    = 1'b0;
    mat_raddr = {i_q, j_q};
    unique case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          vec_wdata = value_i;
          case (req_type_i)
            REQ_MAT: mat_we = row_ok && col_ok;
            REQ_RHS: begin
              vec_we    = row_ok;
              vec_waddr = {V_B, row_idx};
            end
            REQ_X: begin
              vec_we    = row_ok;
              vec_waddr = {V_X, row_idx};
            end
            default: ;
          endcase
        end
      end
      ST_RDA: begin
        mat_re = 1'b1;
        vec_re = 1'b1;
      end
      ST_RDB: begin
        vec_re    = 1'b1;
        vec_raddr = {desc.vb, (desc.op == OP_MV) ? j_q : i_q};
      end
      ST_WB: begin
        vec_waddr = {desc.vd, i_q};
        vec_we    = (desc.op != OP_DOT) && ((desc.op != OP_MV) || j_last);
      end
      ST_OUTRD: begin
        vec_re    = 1'b1;
        vec_raddr = {V_X, i_q};
      end
      default: ;
    endcase
  end

  assign mul_a     = (desc.op == OP_AXPY) ? (desc.sel ? alpha_q : beta_q) : a_q;
  assign mul_start = (st_q == ST_CAP) && is_mul;
  assign div_start = (st_q == ST_STEP) && ((desc.op == OP_BETA) || (desc.op == OP_ALPHA));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_xfer && (req_type_i == REQ_SOLVE)) begin
          st_d = (maxit_q == 16'd0) ? ST_OUTRD : ST_STEP;
        end
      end
      ST_STEP: begin
        case (desc.op)
          OP_ENERGY: st_d = ST_EN1;
          OP_BETA, OP_ALPHA: st_d = ST_DIVW;
          OP_END: st_d = ((iter_inc < {1'b0, maxit_q}) && !cvg_q) ? ST_STEP : ST_OUTRD;
          default: st_d = ST_RDA;
        endcase
      end
      ST_RDA:    st_d = ST_RDB;
      ST_RDB:    st_d = ST_CAP;
      ST_CAP:    st_d = is_mul ? ST_MULW : ST_WB;
      ST_MULW:   if (mul_done) st_d = ST_WB;
      ST_WB:     st_d = step_done ? ST_STEP : ST_RDA;
      ST_EN1:    st_d = ST_EN2;
      ST_EN2:    st_d = ST_EN3;
      ST_EN3:    st_d = ST_STEP;
      ST_DIVW:   if (div_done) st_d = ST_STEP;
      ST_OUTRD:  st_d = ST_OUTCAP;
      ST_OUTCAP: if (out_load) st_d = i_last ? ST_IDLE : ST_OUTRD;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      size_q      <= 5'd16;
      maxit_q     <= 16'd1000;
      tol_q       <= 41'd4295;
      xvalid_q    <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= 64'sd0;
      iter_q      <= 16'd0;
      cvg_q       <= 1'b0;
      step_q      <= 5'd0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SIZE:  size_q  <= cfg_data_i[4:0];
          CFG_MAXIT: maxit_q <= cfg_data_i[15:0];
          CFG_TOL:   tol_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (vec_we && (vec_waddr[VAW-1:IW] == V_X)) begin
        xvalid_q[vec_waddr[IW-1:0]] <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
      if ((st_q == ST_IDLE) && in_xfer && (req_type_i == REQ_SOLVE)) begin
        iter_q <= 16'd0;
        cvg_q  <= 1'b0;
        step_q <= 5'd0;
      end
      if (st_q == ST_EN2) prev_q <= en_q;
      if ((st_q == ST_EN3) && (iter_q != 16'd0) && (mag(diff_q) < {23'd0, tol_q})) begin
        cvg_q <= 1'b1;
      end
      if (((st_q == ST_WB) && step_done) || (st_q == ST_EN3) ||
          ((st_q == ST_DIVW) && div_done)) begin
        step_q <= step_d;
      end
      if ((st_q == ST_STEP) && (desc.op == OP_END)) begin
        iter_q <= iter_inc[15:0];
        step_q <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_re) xmask_q <= (vec_raddr[VAW-1:IW] == V_X) && !xvalid_q[vec_raddr[IW-1:0]];
    unique case (st_q)
      ST_IDLE: begin
        n_q <= n_sel;
        i_q <= '0;
      end
      ST_STEP: begin
        i_q   <= '0;
        j_q   <= '0;
        acc_q <= 64'sd0;
      end
      ST_RDB: a_q <= (desc.op == OP_MV) ? mat_rdata : vec_rd;
      ST_WB: begin
        case (desc.op)
          OP_MV: begin
            if (j_last) begin
              acc_q <= 64'sd0;
              j_q   <= '0;
              i_q   <= i_q + IW'(1);
            end else begin
              acc_q <= acc_new;
              j_q   <= j_q + IW'(1);
            end
          end
          OP_DOT: begin
            acc_q <= acc_new;
            i_q   <= i_q + IW'(1);
            if (i_last) begin
              if (desc.sel) t1_q <= acc_new;
              else t0_q <= acc_new;
            end
          end
          default: i_q <= i_q + IW'(1);
        endcase
      end
      ST_EN1: en_q   <= sadd(t0_q >>> 1, t1_q);
      ST_EN2: diff_q <= ssub(prev_q, en_q);
      ST_DIVW: begin
        if (div_done) begin
          if (desc.op == OP_BETA) beta_q <= ssub(64'sd0, div_q);
          else alpha_q <= div_q;
        end
      end
      ST_OUTCAP: begin
        if (out_load) begin
          index_q <= 4'(i_q);
          sol_q   <= vec_rd;
          last_q  <= i_last;
          ocvg_q  <= cvg_q;
          oiter_q <= iter_q;
          i_q     <= i_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  cgs_ram #(.WIDTH(64), .DEPTH(1 << MAW)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .re_i    (mat_re),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  cgs_ram #(.WIDTH(64), .DEPTH(1 << VAW)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .re_i    (vec_re),
    .raddr_i (vec_raddr),
    .rdata_o (vec_rdata)
  );

  cgs_fmul u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (vec_rd),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  cgs_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t0_q),
    .den_i   (t1_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign in_ready_o        = (st_q == ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign index_o           = index_q;
  assign solution_o        = sol_q;
  assign last_o            = last_q;
  assign converged_o       = ocvg_q;
  assign iterations_used_o = oiter_q;

endmodule

@@ design/cgs_checker.sv @@
// Port-level checker for the solver and the bind that attaches it to the top level.
module cgs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  index_o,
  input logic [63:0] solution_o,
  input logic        last_o,
  input logic        converged_o,
  input logic [15:0] iterations_used_o
);
  import cgs_pkg::*;

  // A solve transfer keeps the input side closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_SOLVE) |=> !in_ready_o)
    else $error("input accepted right after a solve transfer");

  // While a non-final solution element is offered, more follow, so the block stays busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input side opened in the middle of a solution run");

  // Convergence needs at least two iterations to compare energies.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> iterations_used_o > 16'd1)
    else $error("convergence flagged with fewer than two iterations");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(solution_o) && $stable(index_o))
    else $error("stalled result changed");

endmodule

bind conjugate_gradient_solver cgs_checker u_cgs_checker (.*);

@@ dv/tb_conjugate_gradient_solver.sv @@
// Self-checking testbench of the conjugate-gradient solver with a fixed-point solve predictor.
`timescale 1ns / 1ps

module tb_conjugate_gradient_solver;
  import cgs_pkg::*;

  typedef logic signed [63:0] q_t;
  typedef q_t vec_t [16];

  typedef struct {
    logic [3:0]  index;
    q_t          solution;
    logic        last;
    logic        converged;
    logic [15:0] iterations;
  } sol_elem_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  code;
    logic [3:0]  row;
    logic [3:0]  col;
    q_t          value;
    bit          typed;
    q_t          t_sol;
    bit          t_cvg;
    int          t_iter;
  } stim_row_t;

  localparam q_t ONE = 64'sh1_0000_0000;
  localparam int QUIET_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [3:0]  row_i = '0;
  logic [3:0]  col_i = '0;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  index_o;
  logic [63:0] solution_o;
  logic        last_o;
  logic        converged_o;
  logic [15:0] iterations_used_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [40:0] cfg_data_i = '0;

  conjugate_gradient_solver uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  q_t          mat_p [16][16];
  vec_t        rhs_p, x_p, p0_p;
  q_t          prev_energy_p;
  logic [4:0]  size_p;
  logic [15:0] maxit_p;
  logic [40:0] tol_p;

  sol_elem_t solution_q [$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        items_sent = 0;
  bit        calm = 1'b0;
  int        stall_credits = 0;
  int        stalls_done = 0;

  function automatic q_t sat128(input logic signed [127:0] v);
    if (v[127:63] != {65{v[127]}}) return v[127] ? Q_MIN : Q_MAX;
    return v[63:0];
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return sat128(s);
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    logic signed [127:0] s;
    s = a;
    s = s - b;
    return sat128(s);
  endfunction

  function automatic q_t q_mul(input q_t a, input q_t b);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    return sat128(p >>> 32);
  endfunction

  function automatic q_t q_div(input q_t num, input q_t den);
    logic signed [127:0] nn, dd;
    if (den == 0) return '0;
    nn = num;
    nn = nn <<< 32;
    dd = den;
    return sat128(nn / dd);
  endfunction

  function automatic void mat_times(input int n, input vec_t v, output vec_t r);
    q_t acc;
    r = '{default: '0};
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < n; j++) acc = q_add(acc, q_mul(mat_p[i][j], v[j]));
      r[i] = acc;
    end
  endfunction

  function automatic q_t dot_prod(input int n, input vec_t u, input vec_t v);
    q_t acc;
    acc = '0;
    for (int i = 0; i < n; i++) acc = q_add(acc, q_mul(u[i], v[i]));
    return acc;
  endfunction

  function automatic int active_size();
    if (size_p == 0) return 1;
    if (size_p > 16) return 16;
    return int'(size_p);
  endfunction

  // Runs the whole solve on the predictor state and returns the results it emits.
  task automatic cg_solve_predict(output sol_elem_t res [$]);
    vec_t ax, r, ar, ap0, p1, ap1;
    q_t e, old_e, beta, na, da, alpha, d;
    logic [63:0] m;
    int n, iters;
    bit cvg;
    sol_elem_t el;
    n = active_size();
    iters = 0;
    cvg = 1'b0;
    while (iters < maxit_p && !cvg) begin
      old_e = prev_energy_p;
      mat_times(n, x_p, ax);
      e = dot_prod(n, x_p, ax) >>> 1;
      e = q_add(e, dot_prod(n, x_p, rhs_p));
      prev_energy_p = e;
      for (int i = 0; i < n; i++) r[i] = q_sub(rhs_p[i], ax[i]);
      if (iters == 0) begin
        p1 = r;
      end else begin
        mat_times(n, r, ar);
        mat_times(n, p0_p, ap0);
        beta = q_sub('0, q_div(dot_prod(n, p0_p, ar), dot_prod(n, p0_p, ap0)));
        for (int i = 0; i < n; i++) p1[i] = q_add(r[i], q_mul(beta, p0_p[i]));
      end
      mat_times(n, p1, ap1);
      na = dot_prod(n, p1, r);
      da = dot_prod(n, p1, ap1);
      if (iters > 0) begin
        d = q_sub(old_e, e);
        m = d[63] ? 64'd0 - d : d;
        if (m < {23'd0, tol_p}) cvg = 1'b1;
      end
      alpha = q_div(na, da);
      for (int i = 0; i < n; i++) begin
        x_p[i] = q_add(x_p[i], q_mul(alpha, p1[i]));
        p0_p[i] = p1[i];
      end
      iters++;
    end
    res = {};
    for (int i = 0; i < n; i++) begin
      el.index = 4'(i);
      el.solution = x_p[i];
      el.last = (i == n - 1);
      el.converged = cvg;
      el.iterations = 16'(iters);
      res.push_back(el);
    end
  endtask

  task automatic send_item(input logic [1:0] req, input logic [3:0] r, input logic [3:0] c,
                           input q_t v, input bit typed = 1'b0, input q_t t_sol = '0,
                           input bit t_cvg = 1'b0, input int t_iter = 0);
    sol_elem_t res [$];
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_i <= r;
    col_i <= c;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    case (req)
      REQ_MAT: mat_p[r][c] = v;
      REQ_RHS: rhs_p[r] = v;
      REQ_X:   x_p[r] = v;
      default: begin
        cg_solve_predict(res);
        foreach (res[i]) begin
          if (typed) begin
            res[i].solution = t_sol;
            res[i].converged = t_cvg;
            res[i].iterations = 16'(t_iter);
          end
          solution_q.push_back(res[i]);
        end
      end
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [40:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIZE:  size_p = data[4:0];
      CFG_MAXIT: maxit_p = data[15:0];
      default:   tol_p = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic q_t rand_val();
    int signed w;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    w = $urandom_range(0, 16000);
    w = w - 8000;
    return (q_t'(w) <<< 22) + $urandom_range(0, 22'h3F_FFFF);
  endfunction

  function automatic q_t rand_diag();
    if ($urandom_range(0, 9) == 0) return rand_val();
    return (q_t'($urandom_range(16, 48)) <<< 30) + $urandom_range(0, 22'h3F_FFFF);
  endfunction

  // Output side: random short stalls, plus a long hold-off when one is requested.
  int hold_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (stall_credits > stalls_done && out_valid_o && hold_left == 0) begin
      stalls_done++;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(1, 3) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sol_elem_t ex;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[conjugate_gradient_solver] ERROR");
        $finish;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (solution_q.size() == 0) begin
        $error("unexpected result transfer: index %0d solution %h", index_o, solution_o);
        fail_count++;
      end else begin
        ex = solution_q.pop_front();
        if (index_o !== ex.index) begin
          $error("index: expected %0d, got %0d", ex.index, index_o);
          fail_count++;
        end
        if (solution_o !== ex.solution) begin
          $error("solution: expected %h, got %h", ex.solution, solution_o);
          fail_count++;
        end
        if (last_o !== ex.last) begin
          $error("last: expected %0b, got %0b", ex.last, last_o);
          fail_count++;
        end
        if (converged_o !== ex.converged) begin
          $error("converged: expected %0b, got %0b", ex.converged, converged_o);
          fail_count++;
        end
        if (iterations_used_o !== ex.iterations) begin
          $error("iterations_used: expected %0d, got %0d", ex.iterations, iterations_used_o);
          fail_count++;
        end
      end
    end
  end

  stim_row_t directed [$];

  initial begin
    int n, loaded_n;
    bit stalled, pressure;
    mat_p = '{default: '{default: '0}};
    rhs_p = '{default: '0};
    x_p = '{default: '0};
    p0_p = '{default: '0};
    prev_energy_p = '0;
    size_p = 5'd16;
    maxit_p = 16'd1000;
    tol_p = 41'd4295;

    directed = '{
      '{1, CFG_MAXIT, 0, 0, 0, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, 0, 0, 0},
      '{1, CFG_SIZE, 0, 0, 31, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, 0, 0, 0},
      '{1, CFG_SIZE, 0, 0, 0, 0, 0, 0, 0},
      '{0, REQ_X, 0, 0, Q_MAX, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, Q_MAX, 0, 0},
      '{0, REQ_X, 0, 0, Q_MIN, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, Q_MIN, 0, 0},
      '{0, REQ_MAT, 0, 0, ONE, 0, 0, 0, 0},
      '{0, REQ_RHS, 0, 0, 2 * ONE, 0, 0, 0, 0},
      '{0, REQ_X, 0, 0, 0, 0, 0, 0, 0},
      '{1, CFG_MAXIT, 0, 0, 1, 0, 0, 0, 0},
      '{1, CFG_TOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, 2 * ONE, 0, 1},
      '{1, CFG_TOL, 0, 0, 64'h100_0000_0000, 0, 0, 0, 0},
      '{1, CFG_MAXIT, 0, 0, 65535, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 0, 0, 0, 1, 2 * ONE, 1, 2},
      '{0, REQ_MAT, 0, 0, Q_MAX, 0, 0, 0, 0},
      '{0, REQ_RHS, 0, 0, Q_MIN, 0, 0, 0, 0},
      '{0, REQ_X, 0, 0, Q_MAX, 0, 0, 0, 0},
      '{1, CFG_MAXIT, 0, 0, 3, 0, 0, 0, 0},
      '{0, REQ_SOLVE, 15, 15, -1, 0, 0, 0, 0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        write_reg(directed[k].code, directed[k].value[40:0]);
      end else begin
        send_item(directed[k].code, directed[k].row, directed[k].col, directed[k].value,
                  directed[k].typed, directed[k].t_sol, directed[k].t_cvg,
                  directed[k].t_iter);
      end
    end

    loaded_n = 0;
    stalled = 1'b0;
    while (items_sent < 230) begin
      if (items_sent > 190) calm = 1'b1;
      n = $urandom_range(1, 5);
      if (n > loaded_n || $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            send_item(REQ_MAT, i, j, (i == j) ? rand_diag() : rand_val());
            if ($urandom_range(0, 9) == 0) begin
              send_item($urandom_range(0, 2), $urandom_range(0, 15), $urandom_range(0, 15),
                        {$urandom, $urandom});
            end
          end
          send_item(REQ_RHS, i, $urandom_range(0, 15), rand_val());
        end
        loaded_n = n;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) send_item(REQ_X, i, $urandom_range(0, 15), rand_val());
      end
      if (n == 1 && $urandom_range(0, 1) == 0) write_reg(CFG_SIZE, 0);
      else write_reg(CFG_SIZE, n);
      if ($urandom_range(0, 1) == 0) write_reg(CFG_MAXIT, $urandom_range(1, 10));
      else if (maxit_p > 10 || maxit_p == 0) write_reg(CFG_MAXIT, $urandom_range(1, 10));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_TOL, 0);
        1: write_reg(CFG_TOL, 41'h100_0000_0000);
        2: write_reg(CFG_TOL, $urandom_range(0, 1 << 20));
        default: ;
      endcase
      pressure = 1'b0;
      if (!stalled && n >= 3) begin
        stall_credits++;
        stalled = 1'b1;
        pressure = 1'b1;
      end
      send_item(REQ_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), {$urandom, $urandom});
      if (pressure) send_item(REQ_RHS, 4'd0, 4'd0, rhs_p[0]);
      if ($urandom_range(0, 3) == 0) begin
        send_item(REQ_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), rand_val());
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[conjugate_gradient_solver] OK");
    end else begin
      $display("[conjugate_gradient_solver] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cgs_pkg.sv
design/cgs_ram.sv
design/cgs_fmul.sv
design/cgs_fdiv.sv
design/conjugate_gradient_solver.sv
design/cgs_checker.sv
dv/tb_conjugate_gradient_solver.sv
